// ----- rtl/core/cfc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package cfc_pkg;

    // Command and receive selectors carried in s_tuser
    typedef enum logic [2:0] {
        OP_READ_FREQ = 3'd0,
        OP_SET_FREQ  = 3'd1,
        OP_SET_MODE  = 3'd2,
        OP_SPLIT     = 3'd3,
        OP_TOGGLE    = 3'd4,
        OP_RX_BYTE   = 3'd5
    } op_t;

    // Result kind carried in m_tuser
    localparam logic KIND_TX   = 1'b0;
    localparam logic KIND_RESP = 1'b1;

    // Opcode bytes placed in the fifth frame byte
    localparam logic [7:0] CMD_READ_FREQ = 8'h03;
    localparam logic [7:0] CMD_SET_FREQ  = 8'h01;
    localparam logic [7:0] CMD_SET_MODE  = 8'h07;
    localparam logic [7:0] CMD_SPLIT_ON  = 8'h02;
    localparam logic [7:0] CMD_SPLIT_OFF = 8'h82;
    localparam logic [7:0] CMD_TOGGLE    = 8'h81;

    localparam logic [26:0] FREQ_MAX = 27'd99999999;

    // Index of the marked word within a frame
    localparam logic [2:0] FRAME_LAST = 3'd4;

    localparam int CFC_QUEUE_DEPTH = 2;

    // Queue entry: frame bytes (byte 0 lowest) or {mode, freq} for a response
    typedef struct packed {
        logic        kind;
        logic [39:0] body;
    } cfc_entry_t;

    typedef enum logic [1:0] {
        FR_RUN,
        FR_CONV,
        FR_EMIT
    } front_state_t;

endpackage

`default_nettype wire

// ----- rtl/core/cfc_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfc_front
    import cfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [2:0]  op,
    input  wire logic [26:0] freq_value,
    input  wire logic [3:0]  mode_code,
    input  wire logic        split_on,
    input  wire logic [7:0]  rx_byte,
    input  wire logic        q_full,
    output logic             push_valid,
    output cfc_entry_t       push_entry,
    output logic             conv_busy
);

    localparam int BIN_W       = 28;
    localparam int BCD_W       = 32;
    localparam int STEPS       = 4;
    localparam int CONV_CYCLES = BIN_W / STEPS;
    localparam int CNT_W       = $clog2(CONV_CYCLES);

    front_state_t     state_reg, state_next;
    logic [BIN_W-1:0] bin_reg, bin_next;
    logic [BCD_W-1:0] bcd_reg, bcd_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [2:0]       rx_count_reg, rx_count_next;
    logic [27:0]      rx_accum_reg, rx_accum_next;

    logic             accept;
    logic [26:0]      freq_sat;
    logic [7:0]       pair;
    logic             mode_ok;
    logic [BIN_W-1:0] bin_w;
    logic [BCD_W-1:0] bcd_w;

    // One shift-and-add-3 step of binary to packed BCD
    function automatic logic [BCD_W-1:0] dd_step(input logic [BCD_W-1:0] v, input logic b);
        logic [BCD_W-1:0] a;
        a = v;
        for (int d = 0; d < BCD_W / 4; d++) begin
            if (a[d*4 +: 4] >= 4'd5) begin
                a[d*4 +: 4] = a[d*4 +: 4] + 4'd3;
            end
        end
        return {a[BCD_W-2:0], b};
    endfunction

    function automatic logic [19:0] pair_weight(input logic [1:0] idx);
        case (idx)
            2'd0:    return 20'd1000000;
            2'd1:    return 20'd10000;
            2'd2:    return 20'd100;
            default: return 20'd1;
        endcase
    endfunction

    function automatic logic [3:0] decode_mode(input logic [7:0] b);
        unique case (b)
            8'h00:   return 4'd0;
            8'h01:   return 4'd1;
            8'h02:   return 4'd2;
            8'h03:   return 4'd3;
            8'h04:   return 4'd4;
            8'h06:   return 4'd5;
            8'h08:   return 4'd6;
            8'h0A:   return 4'd7;
            8'h0C:   return 4'd8;
            default: return 4'd9;
        endcase
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= FR_RUN;
            cnt_reg      <= '0;
            rx_count_reg <= '0;
            rx_accum_reg <= '0;
        end else begin
            state_reg    <= state_next;
            cnt_reg      <= cnt_next;
            rx_count_reg <= rx_count_next;
            rx_accum_reg <= rx_accum_next;
        end
    end

    // Conversion datapath needs no reset
    always_ff @(posedge aclk) begin
        bin_reg <= bin_next;
        bcd_reg <= bcd_next;
    end

    // Saturate the frequency, weigh the received pair, screen the mode code
    always_comb begin
        freq_sat = (freq_value > FREQ_MAX) ? FREQ_MAX : freq_value;
        pair     = 8'({4'b0, rx_byte[7:4]} * 8'd10) + {4'b0, rx_byte[3:0]};
        case (mode_code) inside
            4'h0, 4'h1, 4'h2, 4'h3, 4'h4, 4'h8, 4'hA, 4'hC: mode_ok = 1'b1;
            default:                                        mode_ok = 1'b0;
        endcase
    end

    // Advance the converter by several bit steps per cycle
    always_comb begin
        bcd_w = bcd_reg;
        bin_w = bin_reg;
        for (int j = 0; j < STEPS; j++) begin
            bcd_w = dd_step(bcd_w, bin_w[BIN_W-1]);
            bin_w = {bin_w[BIN_W-2:0], 1'b0};
        end
    end

    // Classify accepted words and push queue entries
    always_comb begin
        state_next    = state_reg;
        bin_next      = bin_reg;
        bcd_next      = bcd_reg;
        cnt_next      = cnt_reg;
        rx_count_next = rx_count_reg;
        rx_accum_next = rx_accum_reg;
        push_valid    = 1'b0;
        push_entry    = '0;
        s_tready      = 1'b0;
        accept        = 1'b0;

        unique case (state_reg)
            FR_RUN: begin
                s_tready = !q_full;
                accept   = s_tvalid && !q_full;
                if (accept) begin
                    case (op_t'(op))
                        OP_READ_FREQ: begin
                            rx_count_next         = '0;
                            rx_accum_next         = '0;
                            push_valid            = 1'b1;
                            push_entry.kind       = KIND_TX;
                            push_entry.body[39:32] = CMD_READ_FREQ;
                        end
                        OP_SET_FREQ: begin
                            rx_count_next = '0;
                            rx_accum_next = '0;
                            bin_next      = {1'b0, freq_sat};
                            bcd_next      = '0;
                            cnt_next      = '0;
                            state_next    = FR_CONV;
                        end
                        OP_SET_MODE: begin
                            if (mode_ok) begin
                                push_valid             = 1'b1;
                                push_entry.kind        = KIND_TX;
                                push_entry.body[3:0]   = mode_code;
                                push_entry.body[39:32] = CMD_SET_MODE;
                            end
                        end
                        OP_SPLIT: begin
                            push_valid             = 1'b1;
                            push_entry.kind        = KIND_TX;
                            push_entry.body[39:32] = split_on ? CMD_SPLIT_ON : CMD_SPLIT_OFF;
                        end
                        OP_TOGGLE: begin
                            rx_count_next          = '0;
                            rx_accum_next          = '0;
                            push_valid             = 1'b1;
                            push_entry.kind        = KIND_TX;
                            push_entry.body[39:32] = CMD_TOGGLE;
                        end
                        OP_RX_BYTE: begin
                            if (!rx_count_reg[2]) begin
                                rx_accum_next = rx_accum_reg
                                              + 28'(pair) * 28'(pair_weight(rx_count_reg[1:0]));
                                rx_count_next = rx_count_reg + 3'd1;
                            end else begin
                                rx_count_next          = '0;
                                rx_accum_next          = '0;
                                push_valid             = 1'b1;
                                push_entry.kind        = KIND_RESP;
                                push_entry.body[27:0]  = rx_accum_reg;
                                push_entry.body[31:28] = decode_mode(rx_byte);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            FR_CONV: begin
                bcd_next = bcd_w;
                bin_next = bin_w;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(CONV_CYCLES - 1)) begin
                    state_next = FR_EMIT;
                end
            end
            FR_EMIT: begin
                if (!q_full) begin
                    push_valid             = 1'b1;
                    push_entry.kind        = KIND_TX;
                    push_entry.body        = {CMD_SET_FREQ, bcd_reg[7:0], bcd_reg[15:8],
                                              bcd_reg[23:16], bcd_reg[31:24]};
                    state_next             = FR_RUN;
                end
            end
            default: state_next = FR_RUN;
        endcase
    end

    assign conv_busy = (state_reg != FR_RUN);

endmodule

`default_nettype wire

// ----- rtl/core/cfc_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfc_queue
    import cfc_pkg::*;
#(
    parameter int DEPTH = CFC_QUEUE_DEPTH
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       push_valid,
    input  wire cfc_entry_t push_entry,
    output logic            full,
    output logic            pop_valid,
    output cfc_entry_t      pop_entry,
    input  wire logic       pop
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    cfc_entry_t       slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slot_reg[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Advance pointers and occupancy
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (do_pop)  rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            count_reg <= count_reg + CNT_W'(do_push) - CNT_W'(do_pop);
        end
    end

    // Store the pushed entry
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/cfc_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module cfc_back
    import cfc_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        q_valid,
    input  wire cfc_entry_t  q_entry,
    output logic             q_pop,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,
    output logic             m_tlast,
    output logic             m_tuser
);

    cfc_entry_t cur_reg;
    logic       cur_valid_reg;
    logic [2:0] idx_reg;
    logic       last_word;
    logic       word_done;
    logic [7:0] tx_byte;

    assign last_word = (cur_reg.kind == KIND_RESP) || (idx_reg == FRAME_LAST);
    assign word_done = cur_valid_reg && m_tready;
    assign q_pop     = !cur_valid_reg || (word_done && last_word);

    // Load the next entry or advance through the frame
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            idx_reg       <= '0;
        end else if (q_pop) begin
            cur_valid_reg <= q_valid;
            idx_reg       <= '0;
        end else if (word_done) begin
            idx_reg <= idx_reg + 3'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (q_pop && q_valid) begin
            cur_reg <= q_entry;
        end
    end

    // Select the byte of the current frame word
    always_comb begin
        case (idx_reg)
            3'd0:    tx_byte = cur_reg.body[7:0];
            3'd1:    tx_byte = cur_reg.body[15:8];
            3'd2:    tx_byte = cur_reg.body[23:16];
            3'd3:    tx_byte = cur_reg.body[31:24];
            default: tx_byte = cur_reg.body[39:32];
        endcase
    end

    assign m_tvalid = cur_valid_reg;
    assign m_tuser  = cur_reg.kind;
    assign m_tlast  = (cur_reg.kind == KIND_TX) && (idx_reg == FRAME_LAST);
    assign m_tdata  = (cur_reg.kind == KIND_RESP) ? {cur_reg.body[31:0], 8'h00}
                                                  : {32'h0, tx_byte};

endmodule

`default_nettype wire

// ----- rtl/core/cat_command_frame_codec.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Framer and deframer for a 5-byte radio control protocol. Each command word
// on the s_ side (read freq, set freq, set mode, split, toggle) yields five
// transmit words on the m_ side, the fifth marked by m_tlast; set freq is
// converted to packed BCD (saturating at 99999999), and set mode with an
// unsupported code yields nothing. Received radio bytes collect five at a time
// into one response word carrying the decoded frequency and mode. The output
// drains one word per cycle while m_tready is high; the front end takes one
// word per cycle while the queue has room, except set freq, which holds
// s_tready low while the binary to BCD converter runs four bits per cycle. A
// small queue between front and back lets commands be taken while earlier
// frames are still being sent.
module cat_command_frame_codec
    import cfc_pkg::*;
#(
    parameter int QUEUE_DEPTH = CFC_QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // freq_value[26:0], mode_code[30:27], split_on[31], rx_byte[39:32]
    input  wire logic [39:0] s_tdata,
    // op[2:0]
    input  wire logic [2:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // tx_byte[7:0], freq_read[35:8], mode_read[39:36]
    output logic [39:0]      m_tdata,
    output logic             m_tlast,
    // kind[0]
    output logic             m_tuser
);

    logic       q_full;
    logic       push_valid;
    cfc_entry_t push_entry;
    logic       q_valid;
    cfc_entry_t q_entry;
    logic       q_pop;
    logic       conv_busy;

    cfc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .op         (s_tuser),
        .freq_value (s_tdata[26:0]),
        .mode_code  (s_tdata[30:27]),
        .split_on   (s_tdata[31]),
        .rx_byte    (s_tdata[39:32]),
        .q_full     (q_full),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .conv_busy  (conv_busy)
    );

    cfc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (q_full),
        .pop_valid  (q_valid),
        .pop_entry  (q_entry),
        .pop        (q_pop)
    );

    cfc_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_entry  (q_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    // Only transmit words close a frame
    a_last_is_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> m_tuser == KIND_TX)
        else $error("frame mark on a response word");

    // A response word carries no transmit byte
    a_resp_no_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser == KIND_RESP |-> m_tdata[7:0] == 8'h00)
        else $error("response word with transmit byte");

    // Set freq stalls the input while the converter runs
    a_conv_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && s_tuser == OP_SET_FREQ |=> conv_busy && !s_tready)
        else $error("input taken during conversion");

    // Nothing is pushed into a full queue
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push_valid |-> !q_full)
        else $error("push into full queue");

endmodule

`default_nettype wire
